// ===== hw/rtl/dtzc_pkg.sv =====
package dtzc_pkg;

    localparam int unsigned TimeBits = 32;
    localparam int unsigned WhenBits = 15;
    localparam int unsigned OffBits  = 11;

    localparam logic [2:0] CFG_DST_WHEN = 3'd0;
    localparam logic [2:0] CFG_DST_OFF  = 3'd1;
    localparam logic [2:0] CFG_STD_WHEN = 3'd2;
    localparam logic [2:0] CFG_STD_OFF  = 3'd3;

    localparam logic [7:0] NO_YEAR = 8'd255;

    typedef struct packed {
        logic                req_type;
        logic [TimeBits-1:0] time_value;
    } t_in;

    typedef struct packed {
        logic [TimeBits-1:0] converted_time;
        logic                is_dst;
    } t_out;

    // days before the first of month m in a common year
    function automatic logic [8:0] f_cum_days(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // the same, modulo 7
    function automatic logic [2:0] f_cum_m7(input logic [3:0] m);
        logic [2:0] d;
        unique case (m)
            4'd2:    d = 3'd3;
            4'd3:    d = 3'd3;
            4'd4:    d = 3'd6;
            4'd5:    d = 3'd1;
            4'd6:    d = 3'd4;
            4'd7:    d = 3'd6;
            4'd8:    d = 3'd2;
            4'd9:    d = 3'd5;
            4'd10:   d = 3'd0;
            4'd11:   d = 3'd3;
            4'd12:   d = 3'd5;
            default: d = 3'd0;
        endcase
        return d;
    endfunction

    function automatic logic [TimeBits-1:0] f_off_secs(input logic [OffBits-1:0] o);
        logic [TimeBits-1:0] w;
        logic [TimeBits-1:0] p;
        w = {{(TimeBits-OffBits){o[OffBits-1]}}, o};
        p = TimeBits'(w * 32'd60);
        return p;
    endfunction

    function automatic logic [3:0] f_mod7(input logic [3:0] v);
        return (v >= 4'd7) ? v - 4'd7 : v;
    endfunction

endpackage

// ===== hw/rtl/dst_time_zone_converter_top.sv =====
// An input beat passes the divide state, the year search and, when its year is not cached,
// a rebuild of the change instants, then the compare and done states.
// Throughput: one item at a time; the next input beat is taken the cycle after the result
// is loaded, and a result still waiting in the output register holds the next load.
// The day count comes from one reciprocal multiply; the year search walks one year a cycle.
// Reset (synchronous, active low) clears rules, offsets and instants and marks the cache empty.
module dst_time_zone_converter_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dtzc_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dtzc_pkg::t_out    o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [14:0]       i_cfg_data
);
    import dtzc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_YEAR = 4'd2;
    localparam logic [3:0] S_RDAY = 4'd3;
    localparam logic [3:0] S_RMUL = 4'd4;
    localparam logic [3:0] S_RADD = 4'd5;
    localparam logic [3:0] S_RUTC = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic [25:0] DAY_RECIP = 26'd50903317;

    logic [3:0]          r_state;
    logic [14:0]         r_dst_when, r_std_when;
    logic [10:0]         r_dst_off, r_std_off;
    logic [7:0]          r_cyear;
    logic [31:0]         r_dst_loc, r_std_loc, r_dst_utc, r_std_utc;
    logic                r_dir;
    logic [31:0]         r_t;
    logic [15:0]         r_q;
    logic [15:0]         r_acc;
    logic [2:0]          r_m7;
    logic [7:0]          r_yoff;
    logic                r_sel;
    logic [16:0]         r_rd;
    logic [31:0]         r_prod;
    logic [31:0]         r_loc;
    logic                r_isdst;
    logic                r_ovalid;
    t_out                r_out;

    logic [50:0] recip;
    logic        leap;
    logic [16:0] ysum;
    logic [2:0]  ystep;
    logic [14:0] rule;
    logic [3:0]  mon, m2;
    logic        week0;
    logic [16:0] base;
    logic [3:0]  bm7, dd;
    logic [16:0] n_rd;
    logic [33:0] mul;
    logic [31:0] s_d, s_s;
    logic        n_dst;
    logic [31:0] offs, res;
    logic        load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        // days = (t >> 7) / 675, exact for a 25-bit dividend
        recip   = r_t[31:7] * DAY_RECIP;
        leap    = (r_yoff[1:0] == 2'd2) && (r_yoff != 8'd130);
        ystep   = leap ? 3'd2 : 3'd1;
        ysum    = {1'b0, r_acc} + (leap ? 17'd366 : 17'd365);

        rule  = r_sel ? r_std_when : r_dst_when;
        mon   = rule[9:6];
        if (mon == 4'd0) begin
            mon = 4'd1;
        end else if (mon > 4'd12) begin
            mon = 4'd12;
        end
        week0 = (rule[2:0] == 3'd0);
        m2    = week0 ? mon + 4'd1 : mon;
        if (m2 == 4'd13) begin
            base = ysum;
            bm7  = f_mod7({1'b0, r_m7} + {1'b0, ystep});
        end else begin
            base = {1'b0, r_acc} + {8'd0, f_cum_days(m2)}
                 + {16'd0, (leap && m2 > 4'd2)};
            bm7  = f_mod7({1'b0, r_m7} + {1'b0, f_cum_m7(m2)}
                 + {3'd0, (leap && m2 > 4'd2)});
        end
        // bm7 is the weekday of the base day, 0 = Sunday
        dd   = f_mod7({1'b0, rule[5:3]} + 4'd6 - bm7);
        n_rd = base + {13'd0, dd}
             + (week0 ? 17'h1FFF9 : 17'(7 * (rule[2:0] - 3'd1)));

        mul = r_rd * 17'd86400;

        s_d   = r_dir ? r_dst_loc : r_dst_utc;
        s_s   = r_dir ? r_std_loc : r_std_utc;
        n_dst = (s_s > s_d) ? (r_t >= s_d && r_t < s_s) : !(r_t >= s_s && r_t < s_d);

        offs = f_off_secs(r_isdst ? r_dst_off : r_std_off);
        res  = r_dir ? r_t - offs : r_t + offs;
        load = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dst_when <= '0;
            r_std_when <= '0;
            r_dst_off  <= '0;
            r_std_off  <= '0;
            r_cyear    <= NO_YEAR;
            r_dst_loc  <= '0;
            r_std_loc  <= '0;
            r_dst_utc  <= '0;
            r_std_utc  <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_out    <= '{converted_time: res, is_dst: r_isdst};
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dir   <= i_in_data.req_type;
                        r_t     <= i_in_data.time_value;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_q     <= recip[50:35];
                    r_acc   <= '0;
                    r_m7    <= 3'd4;
                    r_yoff  <= '0;
                    r_state <= S_YEAR;
                end
                S_YEAR: begin
                    if ({1'b0, r_q} >= ysum) begin
                        r_acc  <= ysum[15:0];
                        r_yoff <= r_yoff + 8'd1;
                        r_m7   <= 3'(f_mod7({1'b0, r_m7} + {1'b0, ystep}));
                    end else if (r_cyear == r_yoff) begin
                        r_state <= S_CMP;
                    end else begin
                        r_sel   <= 1'b0;
                        r_state <= S_RDAY;
                    end
                end
                S_RDAY: begin
                    r_rd    <= n_rd;
                    r_state <= S_RMUL;
                end
                S_RMUL: begin
                    r_prod  <= mul[31:0];
                    r_state <= S_RADD;
                end
                S_RADD: begin
                    r_loc <= r_prod + {15'd0, 17'(rule[14:10]) * 17'd3600};
                    if (r_sel) begin
                        r_std_loc <= r_prod + {15'd0, 17'(rule[14:10]) * 17'd3600};
                    end else begin
                        r_dst_loc <= r_prod + {15'd0, 17'(rule[14:10]) * 17'd3600};
                    end
                    r_state <= S_RUTC;
                end
                S_RUTC: begin
                    if (r_sel) begin
                        r_std_utc <= r_loc - f_off_secs(r_dst_off);
                        r_cyear   <= r_yoff;
                        r_state   <= S_CMP;
                    end else begin
                        r_dst_utc <= r_loc - f_off_secs(r_std_off);
                        r_sel     <= 1'b1;
                        r_state   <= S_RDAY;
                    end
                end
                S_CMP: begin
                    r_isdst <= n_dst;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DST_WHEN: begin
                        r_dst_when <= i_cfg_data;
                        r_cyear    <= NO_YEAR;
                    end
                    CFG_DST_OFF: begin
                        r_dst_off <= i_cfg_data[10:0];
                        r_cyear   <= NO_YEAR;
                    end
                    CFG_STD_WHEN: begin
                        r_std_when <= i_cfg_data;
                        r_cyear    <= NO_YEAR;
                    end
                    CFG_STD_OFF: begin
                        r_std_off <= i_cfg_data[10:0];
                        r_cyear   <= NO_YEAR;
                    end
                    default: ;
                endcase
            end
        end
    end

    a_cache_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cyear <= 8'd136 || r_cyear == NO_YEAR)
        else $error("cached year out of range");

    a_cfg_inval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx <= CFG_STD_OFF) |=> r_cyear == NO_YEAR)
        else $error("rule write left cache valid");

    a_days_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_YEAR |-> r_q <= 16'd49710)
        else $error("day count out of range");

endmodule

// ===== verif/tb_dst_time_zone_converter_top.sv =====
`timescale 1ns / 1ps

module tb_dst_time_zone_converter_top;
    import dtzc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 50000;
    localparam longint unsigned DAY_SECONDS = 86400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [14:0] i_cfg_data;

    dst_time_zone_converter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // zone state mirrored from the block
    logic [14:0] zone_dst_rule, zone_std_rule;
    int          zone_dst_off, zone_std_off;
    logic [7:0]  zone_year_key;
    logic [31:0] zone_dst_local, zone_std_local, zone_dst_utc, zone_std_utc;

    t_out        conversions_due[$];
    int          send_idle_pct, recv_idle_pct;
    int          error_count;
    int unsigned quiet_cycles;

    function automatic longint unsigned civil_year(input longint unsigned days);
        longint unsigned z, era, doe, yoe, doy, mp, m;
        z   = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        return yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    function automatic longint unsigned month_first_day(input longint unsigned y,
                                                        input longint unsigned m);
        longint unsigned yy, era, yoe, mi, doy, doe;
        yy  = (m <= 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        mi  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mi + 2) / 5;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic logic [31:0] change_instant(input logic [14:0] rule,
                                                   input longint unsigned year);
        longint unsigned week, dow, month, hour, w, m, days, wd, yr;
        week  = rule[2:0];
        dow   = rule[5:3];
        month = rule[9:6];
        hour  = rule[14:10];
        yr    = year;
        if (month == 0) month = 1;
        if (month > 12) month = 12;
        m = month;
        w = week;
        if (w == 0) begin
            m++;
            if (m > 12) begin
                m = 1;
                yr++;
            end
            w = 1;
        end
        days = month_first_day(yr, m);
        wd   = ((days + 4) % 7) + 1;
        days = days + 7 * (w - 1) + (dow + 7 - wd) % 7;
        if (week == 0) days = days - 7;
        return 32'(days * DAY_SECONDS + hour * 3600);
    endfunction

    function automatic bit in_daylight(input logic [31:0] t, input logic [31:0] d_s,
                                       input logic [31:0] s_s);
        if (s_s > d_s) return (t >= d_s) && (t < s_s);
        return !((t >= s_s) && (t < d_s));
    endfunction

    function automatic t_out convert_time(input t_in req);
        longint unsigned yr;
        logic [7:0]      key;
        bit              dst;
        int              off;
        t_out            res;
        yr  = civil_year(longint'(req.time_value) / DAY_SECONDS);
        key = 8'(yr - 1970);
        if (zone_year_key == NO_YEAR || zone_year_key != key) begin
            zone_dst_local = change_instant(zone_dst_rule, yr);
            zone_std_local = change_instant(zone_std_rule, yr);
            zone_dst_utc   = zone_dst_local - 32'(zone_std_off * 60);
            zone_std_utc   = zone_std_local - 32'(zone_dst_off * 60);
            zone_year_key  = key;
        end
        if (req.req_type)
            dst = in_daylight(req.time_value, zone_dst_local, zone_std_local);
        else
            dst = in_daylight(req.time_value, zone_dst_utc, zone_std_utc);
        off = (dst ? zone_dst_off : zone_std_off) * 60;
        res.converted_time = req.req_type ? req.time_value - 32'(off)
                                          : req.time_value + 32'(off);
        res.is_dst = dst;
        return res;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (conversions_due.size() == 0) begin
                    $display("%0t: unexpected beat %h", $realtime, o_out_data);
                    error_count++;
                end else begin
                    if (o_out_data.converted_time !== conversions_due[0].converted_time) begin
                        $display("%0t: converted_time expected %h actual %h", $realtime,
                                 conversions_due[0].converted_time,
                                 o_out_data.converted_time);
                        error_count++;
                    end
                    if (o_out_data.is_dst !== conversions_due[0].is_dst) begin
                        $display("%0t: is_dst expected %b actual %b", $realtime,
                                 conversions_due[0].is_dst, o_out_data.is_dst);
                        error_count++;
                    end
                    void'(conversions_due.pop_front());
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input bit to_utc, input logic [31:0] t);
        t_in req;
        req.req_type   = to_utc;
        req.time_value = t;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        conversions_due.push_back(convert_time(req));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (conversions_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_DST_WHEN: zone_dst_rule = val;
            CFG_DST_OFF:  zone_dst_off  = $signed(val[10:0]);
            CFG_STD_WHEN: zone_std_rule = val;
            CFG_STD_OFF:  zone_std_off  = $signed(val[10:0]);
            default: ;
        endcase
        if (idx <= CFG_STD_OFF) zone_year_key = NO_YEAR;
    endtask

    task automatic set_zone(input logic [14:0] dw, input int doff, input logic [14:0] sw,
                            input int soff);
        drain();
        write_reg(CFG_DST_WHEN, dw);
        write_reg(CFG_DST_OFF, 15'(doff));
        write_reg(CFG_STD_WHEN, sw);
        write_reg(CFG_STD_OFF, 15'(soff));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [14:0] pack_rule(input int week, input int dow, input int month,
                                              input int hour);
        return {5'(hour), 4'(month), 3'(dow), 3'(week)};
    endfunction

    function automatic logic [14:0] random_rule;
        return pack_rule($urandom_range(5), $urandom_range(1, 7), $urandom_range(1, 12),
                         $urandom_range(23));
    endfunction

    // time close to a change point of a random year, or anywhere
    function automatic logic [31:0] pick_time;
        longint unsigned yr;
        logic [31:0]     base;
        int              sel;
        sel = $urandom_range(9);
        if (sel < 2) return $urandom;
        yr   = $urandom_range(1970, 2105);
        base = change_instant(sel < 6 ? zone_dst_rule : zone_std_rule, yr);
        case ($urandom_range(3))
            0: return base + 32'($urandom_range(2)) - 32'd1;
            1: return base - 32'(zone_std_off * 60) + 32'($urandom_range(2)) - 32'd1;
            2: return base - 32'(zone_dst_off * 60) + 32'($urandom_range(2)) - 32'd1;
            default: return base + 32'($urandom_range(14400)) - 32'd7200;
        endcase
    endfunction

    task automatic test_reset_zone;
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 32'd1_700_000_000);
    endtask

    task automatic test_directed;
        set_zone(pack_rule(2, 1, 3, 2), 840, pack_rule(1, 1, 11, 2), -720);
        send_request(1'b0, 32'd0);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, change_instant(zone_dst_rule, 2024) + 32'(720 * 60));
        send_request(1'b1, change_instant(zone_dst_rule, 2024));
        send_request(1'b0, 32'd1_710_000_000);
        // last Sunday of December, then month and weekday fields at their edges
        set_zone(pack_rule(0, 1, 12, 1), -720, pack_rule(0, 7, 10, 3), 840);
        send_request(1'b0, 32'd1_703_000_000);
        send_request(1'b1, 32'd1_703_500_000);
        set_zone(pack_rule(7, 0, 0, 31), 0, pack_rule(5, 0, 15, 24), 60);
        send_request(1'b0, 32'd1_000_000_000);
        send_request(1'b1, 32'd1_000_000_000);
        set_zone(15'd0, 0, 15'd0, 0);
        send_request(1'b0, 32'd86_400);
        set_zone(15'h7FFF, -1, 15'h7FFF, 1023);
        send_request(1'b1, 32'd4_000_000_000);
        // spare register indexes leave the cache alone
        drain();
        write_reg(3'd4, 15'h7FFF);
        write_reg(3'd7, 15'h5555);
        i_cfg_we <= 1'b0;
        send_request(1'b0, 32'd4_000_000_100);
        // shared cache across directions, then a new year
        send_request(1'b1, 32'd4_000_000_200);
        send_request(1'b0, 32'd2_000_000_000);
    endtask

    task automatic test_random(input int items);
        for (int n = 0; n < items; n++)
            send_request($urandom_range(1), pick_time());
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_data     <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count   = 0;
        quiet_cycles  = 0;
        zone_dst_rule = '0;
        zone_std_rule = '0;
        zone_dst_off  = 0;
        zone_std_off  = 0;
        zone_year_key = NO_YEAR;
        zone_dst_local = '0;
        zone_std_local = '0;
        zone_dst_utc   = '0;
        zone_std_utc   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 81;
        test_reset_zone();
        test_directed();
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 24 : (ph < 6) ? 81 : 0;
            recv_idle_pct = (ph < 3) ? 81 : (ph < 6) ? 24 : 0;
            case (ph)
                0: set_zone(pack_rule(2, 1, 3, 2), -240, pack_rule(1, 1, 11, 2), -300);
                1: set_zone(pack_rule(1, 1, 10, 2), 660, pack_rule(1, 1, 4, 3), 600);
                2: set_zone(pack_rule(0, 1, 3, 1), 840, pack_rule(0, 1, 10, 1), -720);
                3: set_zone(15'h7FFF, -720, 15'd0, 840);
                default: set_zone(random_rule(), $urandom_range(1560) - 720, random_rule(),
                                  $urandom_range(1560) - 720);
            endcase
            test_random(150);
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
